FILE: src/rusi_pkg.sv
`timescale 1ns / 1ps

package rusi_pkg;

    // default field format
    parameter int COORD_WIDTH_DEF = 32;
    parameter int FRAC_BITS_DEF   = 16;

    // fraction bits of the unit direction (Q2.30)
    parameter int UNIT_FRAC = 30;

    // advance and valid for one pipelined unit
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

FILE: src/rusi_sqrt_pipe.sv
`timescale 1ns / 1ps

module rusi_sqrt_pipe #(
    parameter int RAD_W = 62,
    parameter int SB_W  = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rusi_pkg::t_pipe_ctl   i_ctl,
    input  logic [RAD_W-1:0]      i_rad,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_vld,
    output logic [RAD_W/2-1:0]    o_root,
    output logic [SB_W-1:0]       o_sb
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int TR_W   = RAD_W + 1;

    logic [RAD_W-1:0]  s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] s_root [0:ROOT_W];
    logic [SB_W-1:0]   s_sb   [0:ROOT_W];
    logic [ROOT_W:0]   s_v;

    assign s_rem[0]  = i_rad;
    assign s_root[0] = '0;
    assign s_sb[0]   = i_sb;
    assign s_v[0]    = i_ctl.vld;

    // one root bit per stage, remainder kept as radicand minus root squared
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [TR_W-1:0]   n_trial;
        logic              n_take;
        logic [RAD_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [SB_W-1:0]   r_sb;
        logic              r_v;

        assign n_trial = (TR_W'(s_root[k]) << (B + 1)) + (TR_W'(1) << (2 * B));
        assign n_take  = {1'b0, s_rem[k]} >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem  <= n_take ? s_rem[k] - n_trial[RAD_W-1:0] : s_rem[k];
                r_root <= n_take ? (s_root[k] | (ROOT_W'(1) << B)) : s_root[k];
                r_sb   <= s_sb[k];
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_sb[k+1]   = r_sb;
        assign s_v[k+1]    = r_v;
    end

    assign o_vld  = s_v[ROOT_W];
    assign o_root = s_root[ROOT_W];
    assign o_sb   = s_sb[ROOT_W];

endmodule

FILE: src/rusi_div_pipe.sv
`timescale 1ns / 1ps

module rusi_div_pipe #(
    parameter int LANES = 3,
    parameter int DEN_W = 31,
    parameter int Q_W   = 31,
    parameter int SB_W  = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rusi_pkg::t_pipe_ctl                 i_ctl,
    input  logic [LANES-1:0][DEN_W+Q_W-1:0]     i_num,
    input  logic [DEN_W-1:0]                    i_den,
    input  logic [SB_W-1:0]                     i_sb,
    output logic                                o_vld,
    output logic [LANES-1:0][Q_W-1:0]           o_quo,
    output logic [SB_W-1:0]                     o_sb
);

    localparam int RW = DEN_W + Q_W;

    logic [LANES-1:0][RW-1:0]  s_rem [0:Q_W];
    logic [LANES-1:0][Q_W-1:0] s_quo [0:Q_W];
    logic [DEN_W-1:0]          s_den [0:Q_W];
    logic [SB_W-1:0]           s_sb  [0:Q_W];
    logic [Q_W:0]              s_v;

    assign s_rem[0] = i_num;
    assign s_quo[0] = '0;
    assign s_den[0] = i_den;
    assign s_sb[0]  = i_sb;
    assign s_v[0]   = i_ctl.vld;

    // restoring division, one quotient bit per stage in every lane
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [RW-1:0]             n_sub;
        logic [LANES-1:0][RW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_quo;
        logic [LANES-1:0][RW-1:0]  r_rem;
        logic [LANES-1:0][Q_W-1:0] r_quo;
        logic [DEN_W-1:0]          r_den;
        logic [SB_W-1:0]           r_sb;
        logic                      r_v;

        assign n_sub = RW'(s_den[k]) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (s_rem[k][l] >= n_sub) begin
                    n_rem[l] = s_rem[k][l] - n_sub;
                    n_quo[l] = s_quo[k][l] | (Q_W'(1) << B);
                end else begin
                    n_rem[l] = s_rem[k][l];
                    n_quo[l] = s_quo[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_den <= s_den[k];
                r_sb  <= s_sb[k];
            end
        end

        assign s_rem[k+1] = r_rem;
        assign s_quo[k+1] = r_quo;
        assign s_den[k+1] = r_den;
        assign s_sb[k+1]  = r_sb;
        assign s_v[k+1]   = r_v;
    end

    assign o_vld = s_v[Q_W];
    assign o_quo = s_quo[Q_W];
    assign o_sb  = s_sb[Q_W];

endmodule

FILE: src/ray_unit_sphere_intersect_core.sv
`timescale 1ns / 1ps
// Ray against the unit sphere at the origin, fixed point, fully pipelined.
// Input stream s_axis: one ray per transaction, origin x,y,z then direction
// x,y,z, each COORD_WIDTH bits signed with FRAC_BITS fraction bits.
// Output stream m_axis: tuser is the hit flag, tdata holds the hit point and
// the distance along the unit direction; point and distance are zero on a miss.
// A zero direction, a tangent ray, a missed sphere or a root behind the origin
// all report a miss. Out-of-range point components and distances saturate.
// The pipeline depth is set by the two digit-serial square root chains and
// the quotient chain, one bit per stage.
// Throughput is one ray per clock cycle while the receiver does not stall.
// Reset (synchronous, active low) empties every stage; no result is pending.
// When the receiver stalls, a two-entry output buffer takes the item in flight
// and s_axis_tready then falls, freezing the whole pipeline until space opens.
// s_axis_tready depends on registers only.

module ray_unit_sphere_intersect_core #(
    parameter int COORD_WIDTH = rusi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rusi_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // point_x, point_y, point_z, distance, zero pad
    output logic [((4*COORD_WIDTH+6)/8)*8-1:0]    m_axis_tdata,
    // hit
    output logic                                  m_axis_tuser
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int UF   = rusi_pkg::UNIT_FRAC;
    localparam int EW   = UF;
    localparam int LW   = EW + 1;
    localparam int N2W  = 2 * LW;
    localparam int QW   = LW;
    localparam int UW   = QW + 1;
    localparam int PW   = W + UW;
    localparam int AW   = PW + 2;
    localparam int HW   = W + 2;
    localparam int RH   = (HW > F + 1) ? HW : F + 1;
    localparam int DW   = 2 * RH + 3;
    localparam int RDW  = 2 * RH + 2;
    localparam int RTW  = RH + 1;
    localparam int TW   = RTW + 2;
    localparam int MW   = UW + TW;
    localparam int STW  = MW - UF;
    localparam int PTW  = STW + 1;
    localparam int PSW  = $clog2(W);
    localparam int XW   = W + EW;
    localparam int SHW  = $clog2(W + EW) + 1;
    localparam int OTDW = ((4 * W + 6) / 8) * 8;
    localparam int SB1  = 3 * W + 4 + 3 * EW;
    localparam int SB2  = 3 * W + 4;
    localparam int SB3  = 3 * W + 3 * UW + HW + 2;

    localparam logic [AW-1:0] HALF_A = AW'(1) << (UF - 1);
    localparam logic [MW-1:0] HALF_M = MW'(1) << (UF - 1);
    localparam logic [DW-1:0] ONE_C  = DW'(1) << (2 * F);

    typedef struct packed {
        logic         hit;
        logic [W-1:0] px;
        logic [W-1:0] py;
        logic [W-1:0] pz;
        logic [W-2:0] distance;
    } t_result;

    logic w_en;
    rusi_pkg::t_pipe_ctl w_ctl1, w_ctl2, w_ctl3;

    // valid chains of the hand-written stages
    logic [5:0] r_fv;
    logic [4:0] r_gv;
    logic [2:0] r_lv;

    // stage a: capture, magnitudes
    logic [2:0][W-1:0] w_a_d, w_a_mag;
    logic [2:0][W-1:0] r_a_o, r_a_mag;
    logic [2:0]        r_a_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a_d[i]   = s_axis_tdata[(i+3)*W +: W];
            w_a_mag[i] = w_a_d[i][W-1] ? (~w_a_d[i] + W'(1)) : w_a_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_o   <= s_axis_tdata[3*W-1:0];
            r_a_mag <= w_a_mag;
            for (int i = 0; i < 3; i++) r_a_neg[i] <= w_a_d[i][W-1];
        end
    end

    // stage b: largest magnitude
    logic [W-1:0]      w_b_m01, w_b_m;
    logic [2:0][W-1:0] r_b_o, r_b_mag;
    logic [2:0]        r_b_neg;
    logic [W-1:0]      r_b_m;
    logic              r_b_zero;

    assign w_b_m01 = (r_a_mag[0] > r_a_mag[1]) ? r_a_mag[0] : r_a_mag[1];
    assign w_b_m   = (w_b_m01 > r_a_mag[2]) ? w_b_m01 : r_a_mag[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_o    <= r_a_o;
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_m    <= w_b_m;
            r_b_zero <= (w_b_m == '0);
        end
    end

    // stage c: leading one of the largest magnitude
    logic [PSW-1:0]    w_c_p, r_c_p;
    logic [2:0][W-1:0] r_c_o, r_c_mag;
    logic [2:0]        r_c_neg;
    logic              r_c_zero;

    always_comb begin
        w_c_p = '0;
        for (int i = 0; i < W; i++) begin
            if (r_b_m[i]) w_c_p = PSW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_o    <= r_b_o;
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_c_p    <= w_c_p;
        end
    end

    // stage d: scale so the largest component lands in [2^29, 2^30)
    logic [SHW-1:0]     w_d_px, w_d_amt;
    logic               w_d_up;
    logic [2:0][XW-1:0] w_d_sh;
    logic [2:0][EW-1:0] w_d_e, r_d_e;
    logic [2:0][W-1:0]  r_d_o;
    logic [2:0]         r_d_neg;
    logic               r_d_zero;

    assign w_d_px  = SHW'(r_c_p);
    assign w_d_up  = w_d_px >= SHW'(EW - 1);
    assign w_d_amt = w_d_up ? (w_d_px - SHW'(EW - 1)) : (SHW'(EW - 1) - w_d_px);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d_sh[i] = w_d_up ? (XW'(r_c_mag[i]) >> w_d_amt) : (XW'(r_c_mag[i]) << w_d_amt);
            w_d_e[i]  = w_d_sh[i][EW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_o    <= r_c_o;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
            r_d_e    <= w_d_e;
        end
    end

    // stage e: squares of the scaled components
    logic [2:0][2*EW-1:0] r_e_sq;
    logic [2:0][EW-1:0]   r_e_e;
    logic [2:0][W-1:0]    r_e_o;
    logic [2:0]           r_e_neg;
    logic                 r_e_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_e_sq[i] <= r_d_e[i] * r_d_e[i];
            r_e_e    <= r_d_e;
            r_e_o    <= r_d_o;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;
        end
    end

    // stage f: squared length
    logic [N2W-1:0]     r_f_n2;
    logic [2:0][EW-1:0] r_f_e;
    logic [2:0][W-1:0]  r_f_o;
    logic [2:0]         r_f_neg;
    logic               r_f_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_n2   <= N2W'(r_e_sq[0]) + N2W'(r_e_sq[1]) + N2W'(r_e_sq[2]);
            r_f_e    <= r_e_e;
            r_f_o    <= r_e_o;
            r_f_neg  <= r_e_neg;
            r_f_zero <= r_e_zero;
        end
    end

    // direction length
    logic               w_l1_v;
    logic [LW-1:0]      w_l1_len;
    logic [SB1-1:0]     w_l1_sb;
    logic [2:0][W-1:0]  w_l1_o;
    logic [2:0]         w_l1_neg;
    logic               w_l1_zero;
    logic [2:0][EW-1:0] w_l1_e;

    assign w_ctl1.en  = w_en;
    assign w_ctl1.vld = r_fv[5];

    rusi_sqrt_pipe #(
        .RAD_W (N2W),
        .SB_W  (SB1)
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .i_rad   (r_f_n2),
        .i_sb    ({r_f_o, r_f_neg, r_f_zero, r_f_e}),
        .o_vld   (w_l1_v),
        .o_root  (w_l1_len),
        .o_sb    (w_l1_sb)
    );

    assign {w_l1_o, w_l1_neg, w_l1_zero, w_l1_e} = w_l1_sb;

    // unit direction magnitudes
    logic [2:0][LW+QW-1:0] w_q_num;
    logic                  w_q_v;
    logic [2:0][QW-1:0]    w_q_quo;
    logic [SB2-1:0]        w_q_sb;
    logic [2:0][W-1:0]     w_q_o;
    logic [2:0]            w_q_neg;
    logic                  w_q_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) w_q_num[i] = (LW + QW)'(w_l1_e[i]) << UF;
    end

    assign w_ctl2.en  = w_en;
    assign w_ctl2.vld = w_l1_v;

    rusi_div_pipe #(
        .LANES (3),
        .DEN_W (LW),
        .Q_W   (QW),
        .SB_W  (SB2)
    ) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl2),
        .i_num   (w_q_num),
        .i_den   (w_l1_len),
        .i_sb    ({w_l1_o, w_l1_neg, w_l1_zero}),
        .o_vld   (w_q_v),
        .o_quo   (w_q_quo),
        .o_sb    (w_q_sb)
    );

    assign {w_q_o, w_q_neg, w_q_zero} = w_q_sb;

    // stage g: signed unit vector, origin products
    logic [2:0][UW-1:0]  w_g_u, r_g_u;
    logic [2:0][PW-1:0]  w_g_ou, r_g_ou;
    logic [2:0][2*W-1:0] w_g_oo, r_g_oo;
    logic [2:0][W-1:0]   r_g_o;
    logic                r_g_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_g_u[i]  = w_q_neg[i] ? (UW'(0) - UW'(w_q_quo[i])) : UW'(w_q_quo[i]);
            w_g_ou[i] = $signed(w_q_o[i]) * $signed(w_g_u[i]);
            w_g_oo[i] = $signed(w_q_o[i]) * $signed(w_q_o[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_u    <= w_g_u;
            r_g_ou   <= w_g_ou;
            r_g_oo   <= w_g_oo;
            r_g_o    <= w_q_o;
            r_g_zero <= w_q_zero;
        end
    end

    // stage h: dot product and squared origin length
    logic [AW-1:0]      w_h_acc, r_h_acc;
    logic [DW-1:0]      w_h_os, r_h_os;
    logic [2:0][UW-1:0] r_h_u;
    logic [2:0][W-1:0]  r_h_o;
    logic               r_h_zero;

    assign w_h_acc = $signed(r_g_ou[0]) + $signed(r_g_ou[1]) + $signed(r_g_ou[2]);
    assign w_h_os  = $signed(r_g_oo[0]) + $signed(r_g_oo[1]) + $signed(r_g_oo[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_acc  <= w_h_acc;
            r_h_os   <= w_h_os;
            r_h_u    <= r_g_u;
            r_h_o    <= r_g_o;
            r_h_zero <= r_g_zero;
        end
    end

    // stage i: half b rounded half up, c
    logic [AW-1:0]      w_i_rnd;
    logic [HW-1:0]      r_i_h;
    logic [DW-1:0]      r_i_c;
    logic [2:0][UW-1:0] r_i_u;
    logic [2:0][W-1:0]  r_i_o;
    logic               r_i_zero;

    assign w_i_rnd = r_h_acc + HALF_A;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_h    <= w_i_rnd[UF+HW-1:UF];
            r_i_c    <= r_h_os - ONE_C;
            r_i_u    <= r_h_u;
            r_i_o    <= r_h_o;
            r_i_zero <= r_h_zero;
        end
    end

    // stage j: h squared
    logic [2*HW-1:0]    w_j_hh, r_j_hh;
    logic [HW-1:0]      r_j_h;
    logic [DW-1:0]      r_j_c;
    logic [2:0][UW-1:0] r_j_u;
    logic [2:0][W-1:0]  r_j_o;
    logic               r_j_zero;

    assign w_j_hh = $signed(r_i_h) * $signed(r_i_h);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_hh   <= w_j_hh;
            r_j_h    <= r_i_h;
            r_j_c    <= r_i_c;
            r_j_u    <= r_i_u;
            r_j_o    <= r_i_o;
            r_j_zero <= r_i_zero;
        end
    end

    // stage k: discriminant and its sign
    logic [DW-1:0]      w_k_dd;
    logic               w_k_pos;
    logic [RDW-1:0]     r_k_rad;
    logic               r_k_pos;
    logic [HW-1:0]      r_k_h;
    logic [2:0][UW-1:0] r_k_u;
    logic [2:0][W-1:0]  r_k_o;
    logic               r_k_zero;

    assign w_k_dd  = $signed(r_j_hh) - $signed(r_j_c);
    assign w_k_pos = !w_k_dd[DW-1] && (w_k_dd != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_rad  <= w_k_pos ? w_k_dd[RDW-1:0] : '0;
            r_k_pos  <= w_k_pos;
            r_k_h    <= r_j_h;
            r_k_u    <= r_j_u;
            r_k_o    <= r_j_o;
            r_k_zero <= r_j_zero;
        end
    end

    // square root of the discriminant
    logic               w_s_v;
    logic [RTW-1:0]     w_s_root;
    logic [SB3-1:0]     w_s_sb;
    logic [2:0][W-1:0]  w_s_o;
    logic [2:0][UW-1:0] w_s_u;
    logic [HW-1:0]      w_s_h;
    logic               w_s_zero, w_s_pos;

    assign w_ctl3.en  = w_en;
    assign w_ctl3.vld = r_gv[4];

    rusi_sqrt_pipe #(
        .RAD_W (RDW),
        .SB_W  (SB3)
    ) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl3),
        .i_rad   (r_k_rad),
        .i_sb    ({r_k_o, r_k_u, r_k_h, r_k_zero, r_k_pos}),
        .o_vld   (w_s_v),
        .o_root  (w_s_root),
        .o_sb    (w_s_sb)
    );

    assign {w_s_o, w_s_u, w_s_h, w_s_zero, w_s_pos} = w_s_sb;

    // stage l: roots and choice of the nearest positive one
    logic [TW-1:0]      w_l_t1, w_l_t2, w_l_t;
    logic               w_l_hit;
    logic               r_l_hit;
    logic [TW-2:0]      r_l_t;
    logic [2:0][UW-1:0] r_l_u;
    logic [2:0][W-1:0]  r_l_o;

    assign w_l_t1  = $signed({1'b0, w_s_root}) - $signed(w_s_h);
    assign w_l_t2  = -$signed(w_s_h) - $signed({1'b0, w_s_root});
    assign w_l_hit = !w_s_zero && w_s_pos && !w_l_t1[TW-1] && !w_l_t2[TW-1]
                     && ((w_l_t2 != '0) || (w_l_t1 != '0));
    assign w_l_t   = (w_l_t2 != '0) ? w_l_t2 : w_l_t1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_hit <= w_l_hit;
            r_l_t   <= w_l_t[TW-2:0];
            r_l_u   <= w_s_u;
            r_l_o   <= w_s_o;
        end
    end

    // stage m: unit direction times distance
    logic [2:0][MW-1:0] w_m_pr, r_m_pr;
    logic               r_m_hit;
    logic [TW-2:0]      r_m_t;
    logic [2:0][W-1:0]  r_m_o;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m_pr[i] = $signed(r_l_u[i]) * $signed({1'b0, r_l_t});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_pr  <= w_m_pr;
            r_m_hit <= r_l_hit;
            r_m_t   <= r_l_t;
            r_m_o   <= r_l_o;
        end
    end

    // stage n: hit point with saturation, distance
    logic [2:0][MW-1:0]  w_n_rnd;
    logic [2:0][PTW-1:0] w_n_pt;
    logic [2:0][W-1:0]   w_n_sat;
    logic [W-2:0]        w_n_dist;
    t_result             w_n_res, r_n_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n_rnd[i] = r_m_pr[i] + HALF_M;
            w_n_pt[i]  = $signed(r_m_o[i]) + $signed(w_n_rnd[i][MW-1:UF]);
            if ((w_n_pt[i][PTW-1:W-1] == '0) || (w_n_pt[i][PTW-1:W-1] == '1)) begin
                w_n_sat[i] = w_n_pt[i][W-1:0];
            end else begin
                w_n_sat[i] = w_n_pt[i][PTW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
        w_n_dist = (r_m_t[TW-2:W-1] != '0) ? '1 : r_m_t[W-2:0];
        w_n_res.hit      = r_m_hit;
        w_n_res.px       = r_m_hit ? w_n_sat[0] : '0;
        w_n_res.py       = r_m_hit ? w_n_sat[1] : '0;
        w_n_res.pz       = r_m_hit ? w_n_sat[2] : '0;
        w_n_res.distance = r_m_hit ? w_n_dist : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_n_res <= w_n_res;
    end

    // valid chains, frozen while the output buffer is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_gv <= '0;
            r_lv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[4:0], s_axis_tvalid};
            r_gv <= {r_gv[3:0], w_q_v};
            r_lv <= {r_lv[1:0], w_s_v};
        end
    end

    // output register plus skid entry
    logic    r_out_v, r_sk_v;
    t_result r_out, r_sk;

    assign w_en = !r_sk_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (m_axis_tready) r_sk_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v <= r_lv[2];
        end else if (r_lv[2]) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (m_axis_tready) r_out <= r_sk;
        end else if (!r_out_v || m_axis_tready) begin
            r_out <= r_n_res;
        end else begin
            r_sk <= r_n_res;
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.hit;
    assign m_axis_tdata  = OTDW'({r_out.distance, r_out.pz, r_out.py, r_out.px});

`ifndef NO_ASSERTIONS
    // a parked item always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("skid entry holds an item while the output is empty");

    // a stall freezes the valid chains
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_fv) && $stable(r_gv) && $stable(r_lv)))
        else $error("pipeline moved during a stall");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (r_out.px == '0 && r_out.py == '0 && r_out.pz == '0 && r_out.distance == '0))
        else $error("miss transaction with nonzero fields");

    // a hit lies strictly ahead of the origin
    a_hit_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_out.distance != '0))
        else $error("hit transaction with zero distance");
`endif

endmodule
